/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pde_pkg.sv */
// Package: types, constants and helper functions of the Playfair encryptor.
`default_nettype none

package pde_pkg;

    // Item operation codes
    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_MSG = 2'd1;
    localparam logic [1:0] OP_EOM = 2'd2;

    // Square geometry and letter indexes (A = 0)
    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = 25;
    localparam int unsigned LETTERS = 26;
    localparam logic [4:0]  LTR_I   = 5'd8;
    localparam logic [4:0]  LTR_J   = 5'd9;
    localparam logic [4:0]  LTR_X   = 5'd23;
    localparam logic [4:0]  LTR_LAST = 5'd25;

    // ASCII bounds
    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_Z = 8'h5A;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_Z = 8'h7A;
    localparam logic [6:0] CHAR_A     = 7'h41;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the incoming item
        logic key_add;    // append a key letter, clearing a finished square first
        logic fill_step;  // one step of the alphabet walk that completes the square
        logic hold;       // keep the first letter of a pair
        logic pos_read;   // read both letter positions
        logic sq_read;    // read both cipher cells
        logic emit;       // load the result pair into the output buffer
    } pde_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       is_letter;
        logic       square_ready;
        logic       held_valid;
        logic       fill_last;
        logic       obuf_empty;
    } pde_status_t;

    // Decode a byte: {valid, letter index}, J folded to I
    function automatic logic [5:0] letter_of(input logic [7:0] b);
        logic [7:0] d;
        logic       ok;
        logic [4:0] idx;
        d  = 8'h00;
        ok = 1'b0;
        if (b >= ASCII_LO_A && b <= ASCII_LO_Z) begin
            d  = b - ASCII_LO_A;
            ok = 1'b1;
        end else if (b >= ASCII_UP_A && b <= ASCII_UP_Z) begin
            d  = b - ASCII_UP_A;
            ok = 1'b1;
        end
        idx = d[4:0];
        if (idx == LTR_J) begin
            idx = LTR_I;
        end
        return {ok, idx};
    endfunction

    // Row or column step with wrap
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    // Cell number of a row and column: row*5 + col
    function automatic logic [4:0] rc_to_cell(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/playfair_digraph_encryptor_unit.sv */
// A key byte or a first message letter is captured, then decoded. A pair is decoded, its
// positions and then its cipher cells are read, and it is emitted once the output buffer is
// empty; its second letter follows as the sink takes the first. The first message item after
// a key first fills the square from the alphabet through its single write port, then decodes
// again. Items are taken one at a time; key and held letters are accepted while a pair drains.
// Reset (aresetn low, synchronous) empties the square, drops any held letter and results.
`default_nettype none

module playfair_digraph_encryptor_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_char_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_cipher_char,
    output logic            m_last_of_pair,
    output logic            m_end_of_message
);
    import pde_pkg::*;

    pde_cmd_t    cmd;
    pde_status_t status;

    pde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pde_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_op             (s_op),
        .s_char_byte      (s_char_byte),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cipher_char    (m_cipher_char),
        .m_last_of_pair   (m_last_of_pair),
        .m_end_of_message (m_end_of_message)
    );

endmodule

`default_nettype wire

/* rtl/core/pde_ctrl.sv */
// Controller: sequences key appends, square completion and pair lookups.
`default_nettype none

module pde_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pde_pkg::pde_status_t status,
    output pde_pkg::pde_cmd_t        cmd
);
    import pde_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                priority if (status.op == OP_KEY) begin
                    cmd.key_add = status.is_letter;
                end else if (status.op == OP_MSG) begin
                    if (status.is_letter) begin
                        priority if (!status.square_ready) begin
                            state_next = ST_FILL;
                        end else if (!status.held_valid) begin
                            cmd.hold = 1'b1;
                        end else begin
                            cmd.pos_read = 1'b1;
                            state_next   = ST_CALC;
                        end
                    end
                end else if (status.op == OP_EOM) begin
                    if (status.held_valid) begin
                        if (!status.square_ready) begin
                            state_next = ST_FILL;
                        end else begin
                            cmd.pos_read = 1'b1;
                            state_next   = ST_CALC;
                        end
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_DECODE;
                end
            end
            ST_CALC: begin
                cmd.sq_read = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.obuf_empty) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pde_datapath.sv */
// Datapath: key square, position table, pair lookup and output buffer.
`default_nettype none

module pde_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [1:0]           s_op,
    input  wire logic [7:0]           s_char_byte,
    input  wire pde_pkg::pde_cmd_t    cmd,
    output pde_pkg::pde_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [6:0]                m_cipher_char,
    output logic                      m_last_of_pair,
    output logic                      m_end_of_message
);
    import pde_pkg::*;

    // Stores: cell -> letter, letter -> {row, col}
    logic [4:0] key_square_mem [CELLS];
    logic [5:0] letter_pos_mem [LETTERS];

    // Captured item
    logic [1:0] item_op_reg;
    logic [7:0] item_char_reg;

    // Control state
    logic [LETTERS-1:0] letter_used_reg, letter_used_next;
    logic [4:0]         fill_count_reg, fill_count_next;
    logic [2:0]         fill_row_reg, fill_row_next;
    logic [2:0]         fill_col_reg, fill_col_next;
    logic               square_ready_reg, square_ready_next;
    logic [4:0]         walk_idx_reg, walk_idx_next;
    logic [4:0]         held_letter_reg, held_letter_next;
    logic               held_valid_reg, held_valid_next;
    logic [1:0]         ob_cnt_reg, ob_cnt_next;
    logic               ob_head_reg, ob_head_next;

    // Payload registers
    logic [5:0] pos_a_reg, pos_b_reg;
    logic [4:0] chr_a_reg, chr_b_reg;
    logic       eom_pair_reg;
    logic [4:0] ob_a_reg, ob_b_reg;
    logic       ob_eom_reg;

    logic [5:0] dec;
    logic [4:0] cur_idx;
    logic [4:0] letter_b;
    logic       clear_sq;
    logic [4:0] app_idx;
    logic       used_bit;
    logic [4:0] fill_cur;
    logic [2:0] row_cur, col_cur;
    logic       app_en;
    logic       walk_last;
    logic [2:0] r1, c1, r2, c2;
    logic [4:0] cell_a, cell_b;
    logic       pop;
    logic [4:0] ob_letter;

    // Decode the held item
    assign dec      = letter_of(item_char_reg);
    assign cur_idx  = dec[4:0];
    assign letter_b = (item_op_reg == OP_EOM) ? LTR_X : cur_idx;
    assign walk_last = (walk_idx_reg == LTR_LAST);

    assign status.op           = item_op_reg;
    assign status.is_letter    = dec[5];
    assign status.square_ready = square_ready_reg;
    assign status.held_valid   = held_valid_reg;
    assign status.fill_last    = walk_last;
    assign status.obuf_empty   = (ob_cnt_reg == 2'd0);

    // Append a letter: from a key byte or from the alphabet walk
    always_comb begin
        clear_sq = cmd.key_add && square_ready_reg;
        app_idx  = cmd.key_add ? cur_idx : walk_idx_reg;
        used_bit = clear_sq ? 1'b0 : letter_used_reg[app_idx];
        fill_cur = clear_sq ? 5'd0 : fill_count_reg;
        row_cur  = clear_sq ? 3'd0 : fill_row_reg;
        col_cur  = clear_sq ? 3'd0 : fill_col_reg;
        app_en   = (cmd.key_add || (cmd.fill_step && walk_idx_reg != LTR_J))
                   && !used_bit && (fill_cur < 5'(CELLS));
    end

    // Cipher cells by row, column or rectangle rule
    always_comb begin
        r1 = pos_a_reg[5:3];
        c1 = pos_a_reg[2:0];
        r2 = pos_b_reg[5:3];
        c2 = pos_b_reg[2:0];
        priority if (r1 == r2) begin
            cell_a = rc_to_cell(r1, wrap_inc(c1));
            cell_b = rc_to_cell(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
            cell_a = rc_to_cell(wrap_inc(r1), c1);
            cell_b = rc_to_cell(wrap_inc(r2), c2);
        end else begin
            cell_a = rc_to_cell(r1, c2);
            cell_b = rc_to_cell(r2, c1);
        end
    end

    assign pop = m_valid && m_ready;

    // Next values of the control state
    always_comb begin
        letter_used_next  = clear_sq ? '0 : letter_used_reg;
        fill_count_next   = fill_cur;
        fill_row_next     = row_cur;
        fill_col_next     = col_cur;
        square_ready_next = square_ready_reg;
        walk_idx_next     = walk_idx_reg;
        held_letter_next  = held_letter_reg;
        held_valid_next   = held_valid_reg;
        ob_cnt_next       = ob_cnt_reg;
        ob_head_next      = ob_head_reg;

        if (app_en) begin
            letter_used_next[app_idx] = 1'b1;
            fill_count_next = fill_cur + 5'd1;
            fill_col_next   = wrap_inc(col_cur);
            if (col_cur == 3'(SIDE - 1)) begin
                fill_row_next = row_cur + 3'd1;
            end
        end

        if (clear_sq) begin
            square_ready_next = 1'b0;
            held_valid_next   = 1'b0;
            held_letter_next  = 5'd0;
        end

        if (cmd.fill_step) begin
            if (walk_last) begin
                walk_idx_next     = 5'd0;
                square_ready_next = 1'b1;
            end else begin
                walk_idx_next = walk_idx_reg + 5'd1;
            end
        end

        if (cmd.hold) begin
            held_letter_next = cur_idx;
            held_valid_next  = 1'b1;
        end

        if (cmd.emit) begin
            held_letter_next = 5'd0;
            held_valid_next  = 1'b0;
            ob_cnt_next      = 2'd2;
            ob_head_next     = 1'b0;
        end else if (pop) begin
            ob_cnt_next  = ob_cnt_reg - 2'd1;
            ob_head_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_used_reg  <= '0;
            fill_count_reg   <= 5'd0;
            fill_row_reg     <= 3'd0;
            fill_col_reg     <= 3'd0;
            square_ready_reg <= 1'b0;
            walk_idx_reg     <= 5'd0;
            held_letter_reg  <= 5'd0;
            held_valid_reg   <= 1'b0;
            ob_cnt_reg       <= 2'd0;
            ob_head_reg      <= 1'b0;
        end else begin
            letter_used_reg  <= letter_used_next;
            fill_count_reg   <= fill_count_next;
            fill_row_reg     <= fill_row_next;
            fill_col_reg     <= fill_col_next;
            square_ready_reg <= square_ready_next;
            walk_idx_reg     <= walk_idx_next;
            held_letter_reg  <= held_letter_next;
            held_valid_reg   <= held_valid_next;
            ob_cnt_reg       <= ob_cnt_next;
            ob_head_reg      <= ob_head_next;
        end
    end

    // Capture the item on transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_op_reg   <= s_op;
            item_char_reg <= s_char_byte;
        end
    end

    // Write the stores and register their reads
    always_ff @(posedge aclk) begin
        if (app_en) begin
            key_square_mem[fill_cur] <= app_idx;
            letter_pos_mem[app_idx]  <= {row_cur, col_cur};
        end
        if (cmd.pos_read) begin
            pos_a_reg <= letter_pos_mem[held_letter_reg];
            pos_b_reg <= letter_pos_mem[letter_b];
        end
        if (cmd.sq_read) begin
            chr_a_reg    <= key_square_mem[cell_a];
            chr_b_reg    <= key_square_mem[cell_b];
            eom_pair_reg <= (item_op_reg == OP_EOM);
        end
    end

    // Load the output pair
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ob_a_reg   <= chr_a_reg;
            ob_b_reg   <= chr_b_reg;
            ob_eom_reg <= eom_pair_reg;
        end
    end

    assign ob_letter        = ob_head_reg ? ob_b_reg : ob_a_reg;
    assign m_valid          = (ob_cnt_reg != 2'd0);
    assign m_cipher_char    = CHAR_A + {2'b00, ob_letter};
    assign m_last_of_pair   = ob_head_reg;
    assign m_end_of_message = ob_head_reg && ob_eom_reg;

endmodule

`default_nettype wire

/* rtl/core/pde_checker.sv */
// Port checker for the Playfair encryptor and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module pde_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_op,
    input wire logic [7:0] s_char_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [6:0] m_cipher_char,
    input wire logic       m_last_of_pair,
    input wire logic       m_end_of_message
);

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_cipher_char) && $stable(m_last_of_pair), "result changed while stalled")

    // Cipher letters are uppercase
    `ASSERT_CLK(a_out_upper, aclk, aresetn, m_valid |-> m_cipher_char >= 7'h41 && m_cipher_char <= 7'h5A, "cipher letter out of range")

    // End of message marks only the second letter of a pair
    `ASSERT_CLK(a_eom_second, aclk, aresetn, m_valid && m_end_of_message |-> m_last_of_pair, "end of message on first letter")

    // The second letter follows the first transfer at once
    `ASSERT_CLK(a_pair_follow, aclk, aresetn, m_valid && m_ready && !m_last_of_pair |=> m_valid && m_last_of_pair, "pair split")

    // Reset drops pending results
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind playfair_digraph_encryptor_unit pde_checker u_pde_checker (.*);

`default_nettype wire
